>>> design/crce_pkg.sv
package crce_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam int unsigned TAPS = 4;
  localparam int unsigned AXES = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_T2,
    ST_CU,
    ST_T3,
    ST_WT,
    ST_MAC,
    ST_DRAIN,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MUL_SQ,
    MUL_CU,
    MUL_PT
  } mul_sel_e;

  typedef struct packed {
    logic     shift_pt;
    logic     load_t;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic [1:0] tap;
    logic [1:0] axis;
    logic     take_t2;
    logic     take_t3;
    logic     take_wt;
    logic     out_load;
  } dp_cmd_t;

endpackage

>>> design/crce_ctrl.sv
module crce_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             operation_i,
  input  logic             out_stall_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  output crce_pkg::dp_cmd_t cmd_o
);

  localparam logic [3:0] LAST_MAC = 4'(crce_pkg::TAPS * crce_pkg::AXES - 1);

  crce_pkg::ctrl_state_e state_q, state_d;
  logic [3:0]            cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic                  in_take;

  assign in_take = in_valid_i && (state_q == crce_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      crce_pkg::ST_IDLE: begin
        if (in_take && (operation_i == crce_pkg::OP_EVAL)) state_d = crce_pkg::ST_SQ;
      end
      crce_pkg::ST_SQ:    state_d = crce_pkg::ST_T2;
      crce_pkg::ST_T2:    state_d = crce_pkg::ST_CU;
      crce_pkg::ST_CU:    state_d = crce_pkg::ST_T3;
      crce_pkg::ST_T3:    state_d = crce_pkg::ST_WT;
      crce_pkg::ST_WT:    state_d = crce_pkg::ST_MAC;
      crce_pkg::ST_MAC: begin
        if (cnt_q == LAST_MAC) state_d = crce_pkg::ST_DRAIN;
      end
      crce_pkg::ST_DRAIN: state_d = crce_pkg::ST_OUT;
      crce_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) state_d = crce_pkg::ST_IDLE;
      end
      default:            state_d = crce_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = crce_pkg::MUL_PT;
    cmd_o.tap     = cnt_q[1:0];
    cmd_o.axis    = cnt_q[3:2];
    cnt_d         = cnt_q;
    in_stall_o    = 1'b1;
    out_valid_d   = out_valid_q && out_stall_i;
    case (state_q)
      crce_pkg::ST_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.shift_pt = in_take && (operation_i == crce_pkg::OP_LOAD);
        cmd_o.load_t   = in_take && (operation_i == crce_pkg::OP_EVAL);
      end
      crce_pkg::ST_SQ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = crce_pkg::MUL_SQ;
      end
      crce_pkg::ST_T2: cmd_o.take_t2 = 1'b1;
      crce_pkg::ST_CU: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = crce_pkg::MUL_CU;
      end
      crce_pkg::ST_T3: cmd_o.take_t3 = 1'b1;
      crce_pkg::ST_WT: begin
        cmd_o.take_wt = 1'b1;
        cnt_d         = '0;
      end
      crce_pkg::ST_MAC: begin
        cmd_o.mul_en = 1'b1;
        cnt_d        = cnt_q + 4'd1;
      end
      crce_pkg::ST_DRAIN: ;
      crce_pkg::ST_OUT: begin
        // load only once the previous word has left
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crce_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/crce_dp.sv
module crce_dp #(
  parameter int unsigned COORD_WIDTH     = 24,
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  crce_pkg::dp_cmd_t             cmd_i,
  input  logic [PARAM_FRAC_BITS:0]      t_param_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  output logic signed [COORD_WIDTH-1:0] curve_x_o,
  output logic signed [COORD_WIDTH-1:0] curve_y_o,
  output logic signed [COORD_WIDTH-1:0] curve_z_o
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned F   = PARAM_FRAC_BITS;
  localparam int unsigned TW  = F + 1;
  localparam int unsigned WW  = F + 5;
  localparam int unsigned AW  = (CW > F + 2) ? CW : F + 2;
  localparam int unsigned PW  = AW + WW;
  localparam int unsigned ACW = PW + 2;

  localparam logic [TW-1:0]         T_ONE   = TW'(1) << F;
  localparam logic [PW-1:0]         P_HALF  = PW'(1) << (F - 1);
  localparam logic signed [WW-1:0]  W_TWO   = WW'(1) << (F + 1);
  localparam logic signed [ACW-1:0] A_ONE   = ACW'(1) << F;
  localparam logic signed [ACW-1:0] SAT_MAX = {{(ACW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [ACW-1:0] SAT_MIN = {{(ACW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic signed [CW-1:0]  win_q [crce_pkg::TAPS][crce_pkg::AXES];
  logic [TW-1:0]         t_q, t2_q, t3_q;
  logic signed [WW-1:0]  w_q [crce_pkg::TAPS];
  logic signed [WW-1:0]  w_d [crce_pkg::TAPS];
  logic signed [PW-1:0]  p_q;
  logic signed [ACW-1:0] acc_q;
  logic signed [CW-1:0]  res_q [crce_pkg::AXES];
  logic signed [CW-1:0]  out_q [crce_pkg::AXES];
  logic                  mac_q;
  logic [1:0]            tap_q, axis_q;

  logic signed [AW-1:0]  mul_a;
  logic signed [WW-1:0]  mul_b;
  logic [PW-1:0]         p_rnd;
  logic signed [WW-1:0]  st, st2, st3;
  logic signed [ACW-1:0] p_ext, sum, quo;
  logic signed [CW-1:0]  sat_v;

  // round half up: (p + S/2) >> F
  assign p_rnd = p_q + P_HALF;

  assign st  = WW'(t_q);
  assign st2 = WW'(t2_q);
  assign st3 = WW'(t3_q);

  // twice the Catmull-Rom weights in Q.F
  assign w_d[0] = (st2 <<< 1) - st3 - st;
  assign w_d[1] = (st3 <<< 1) + st3 - (st2 <<< 2) - st2 + W_TWO;
  assign w_d[2] = (st2 <<< 2) - (st3 <<< 1) - st3 + st;
  assign w_d[3] = st3 - st2;

  always_comb begin
    case (cmd_i.mul_sel)
      crce_pkg::MUL_SQ: begin
        mul_a = AW'(t_q);
        mul_b = WW'(t_q);
      end
      crce_pkg::MUL_CU: begin
        mul_a = AW'(t2_q);
        mul_b = WW'(t_q);
      end
      default: begin
        mul_a = AW'(win_q[cmd_i.tap][cmd_i.axis]);
        mul_b = w_q[cmd_i.tap];
      end
    endcase
  end

  assign p_ext = ACW'(p_q);
  assign sum   = acc_q + p_ext + A_ONE;
  assign quo   = sum >>> (F + 1);

  always_comb begin
    if (quo > SAT_MAX)      sat_v = SAT_MAX[CW-1:0];
    else if (quo < SAT_MIN) sat_v = SAT_MIN[CW-1:0];
    else                    sat_v = quo[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_q <= 1'b0;
      for (int i = 0; i < crce_pkg::TAPS; i++) begin
        for (int a = 0; a < crce_pkg::AXES; a++) begin
          win_q[i][a] <= '0;
        end
      end
    end else begin
      mac_q <= cmd_i.mul_en && (cmd_i.mul_sel == crce_pkg::MUL_PT);
      if (cmd_i.shift_pt) begin
        // drop the oldest point, append the new one
        for (int i = 0; i < crce_pkg::TAPS - 1; i++) begin
          for (int a = 0; a < crce_pkg::AXES; a++) begin
            win_q[i][a] <= win_q[i+1][a];
          end
        end
        win_q[crce_pkg::TAPS-1][0] <= point_x_i;
        win_q[crce_pkg::TAPS-1][1] <= point_y_i;
        win_q[crce_pkg::TAPS-1][2] <= point_z_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tap_q  <= cmd_i.tap;
    axis_q <= cmd_i.axis;
    if (cmd_i.load_t) begin
      t_q   <= (t_param_i > T_ONE) ? T_ONE : t_param_i;
      acc_q <= '0;
    end
    if (cmd_i.mul_en) p_q <= mul_a * mul_b;
    if (cmd_i.take_t2) t2_q <= p_rnd[F +: TW];
    if (cmd_i.take_t3) t3_q <= p_rnd[F +: TW];
    if (cmd_i.take_wt) begin
      for (int i = 0; i < crce_pkg::TAPS; i++) begin
        w_q[i] <= w_d[i];
      end
    end
    if (mac_q) begin
      if (tap_q == 2'(crce_pkg::TAPS - 1)) begin
        res_q[axis_q] <= sat_v;
        acc_q         <= '0;
      end else begin
        acc_q <= acc_q + p_ext;
      end
    end
    if (cmd_i.out_load) begin
      for (int a = 0; a < crce_pkg::AXES; a++) begin
        out_q[a] <= res_q[a];
      end
    end
  end

  assign curve_x_o = out_q[0];
  assign curve_y_o = out_q[1];
  assign curve_z_o = out_q[2];

endmodule

>>> design/catmull_rom_curve_eval_top.sv
// Catmull-Rom segment evaluator, one shared multiplier sequenced by a controller.
// Load word: taken while idle; the next word can be taken on the following cycle.
// Evaluate word: 2 products for t^2 and t^3, 12 point-by-weight products, then rounding
// and output steps; the next word is taken only after the result is loaded for output.
// A held result stalls only the final step; input is taken while a result waits.
// Reset (async, active low) clears the control point window to zeros and drops out_valid_o.
module catmull_rom_curve_eval_top #(
  parameter int unsigned COORD_WIDTH     = 24,
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [PARAM_FRAC_BITS:0]      t_param_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] curve_x_o,
  output logic signed [COORD_WIDTH-1:0] curve_y_o,
  output logic signed [COORD_WIDTH-1:0] curve_z_o
);

  crce_pkg::dp_cmd_t cmd;

  crce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  crce_dp #(
    .COORD_WIDTH     (COORD_WIDTH),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .t_param_i (t_param_i),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .curve_x_o (curve_x_o),
    .curve_y_o (curve_y_o),
    .curve_z_o (curve_z_o)
  );

endmodule
